// ===== rtl/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// shared widths, reset constants and controller/datapath bundles for the
// mandelbrot escape-time core
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int IN_W  = 31;  // c_real / c_imag width
  localparam int CNT_W = 10;  // iteration count and limit width

  localparam logic [CNT_W-1:0] MAX_ITER_RST = CNT_W'(550);

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture c, clear z and step counter
    logic mul;      // register the three products of z
    logic adv;      // move z to the next orbit point, count the step
    logic res_wr;   // write the result register
    logic res_esc;  // escaped flag for the result being written
  } mbe_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic escape;    // |z|^2 > 4 for the current orbit point
    logic at_limit;  // step counter reached max_iterations
  } mbe_stat_t;

endpackage

// ===== rtl/mbe_ifs.sv =====
// ----------------------------------------------------------------------------
// mbe_ifs
// valid/ready channels for points going in and results coming out
// ----------------------------------------------------------------------------
interface mbe_point_if;
  import mbe_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] c_real;
  logic signed [IN_W-1:0] c_imag;

  modport source (output valid, c_real, c_imag, input ready);
  modport sink   (input valid, c_real, c_imag, output ready);
endinterface

interface mbe_result_if;
  import mbe_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] iteration_count;
  logic             escaped;

  modport source (output valid, iteration_count, escaped, input ready);
  modport sink   (input valid, iteration_count, escaped, output ready);
endinterface

// ===== rtl/mandelbrot_escape_time_core.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core
// escape-time iteration z = z*z + c for one point at a time, exact fixed point
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake       payload
//   point     in   valid / ready   c_real[30:0] s, c_imag[30:0] s (Q.FRAC_BITS)
//   result    out  valid / ready   iteration_count[9:0], escaped
//   cfg       in   cfg_wr_en       cfg_wr_data[9:0] -> max_iterations
//
// one point goes from the accept to the result write through a product state and
// an update state for each of K steps tried (escaping step + 1, or max_iterations),
// plus one more pair that tests the starting z = 0; a new point is accepted only
// after the result of the last one has been written to the result register
// reset is synchronous and clears the sequencer, the result valid flag and
// sets max_iterations to 550; there is no memory to clear
// a stalled result sits in the output register while the next point is taken
// and iterated; only the write of that next result waits for the slot
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_core #(
  parameter int FRAC_BITS = 28
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [mbe_pkg::CNT_W-1:0]   cfg_wr_data,
  mbe_point_if.sink                   point,
  mbe_result_if.source                result
);
  import mbe_pkg::*;

  // command and status bundles between sequencer and datapath
  mbe_cmd_t  cmd;
  mbe_stat_t stat;

  // sequencer: point handshake, step loop, result valid flag
  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (point.valid),
    .in_ready  (point.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: z registers, three multipliers, escape test, counter, limit
  mbe_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .c_real          (point.c_real),
    .c_imag          (point.c_imag),
    .cmd             (cmd),
    .stat            (stat),
    .iteration_count (result.iteration_count),
    .escaped         (result.escaped)
  );

endmodule

// ===== rtl/mbe_dp.sv =====
// ----------------------------------------------------------------------------
// mbe_dp
// orbit datapath: point and z registers, three product registers, escape
// compare, step counter, iteration limit and result register
// ----------------------------------------------------------------------------
module mbe_dp #(
  parameter int FRAC_BITS = 28
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [mbe_pkg::CNT_W-1:0]        cfg_wr_data,
  input  logic signed [mbe_pkg::IN_W-1:0]  c_real,
  input  logic signed [mbe_pkg::IN_W-1:0]  c_imag,
  input  mbe_pkg::mbe_cmd_t                cmd,
  output mbe_pkg::mbe_stat_t               stat,
  output logic [mbe_pkg::CNT_W-1:0]        iteration_count,
  output logic                             escaped
);
  import mbe_pkg::*;

  // z width: |x^2 - y^2| and |2xy| stay within 4 while z has not escaped,
  // so one orbit point is bounded by 4 + |c|
  localparam int MAG_W = ((IN_W - 1) > (FRAC_BITS + 2)) ? (IN_W - 1) : (FRAC_BITS + 2);
  localparam int ZW    = MAG_W + 2;
  localparam int PW    = 2 * ZW;
  localparam logic [PW-1:0] ESC_LIM = PW'(1) << (2 * FRAC_BITS + 2);

  logic signed [IN_W-1:0]  c_re;
  logic signed [IN_W-1:0]  c_im;
  logic signed [ZW-1:0]    zx;
  logic signed [ZW-1:0]    zy;
  logic signed [PW-1:0]    p_xx;
  logic signed [PW-1:0]    p_yy;
  logic signed [PW-1:0]    p_xy;
  logic [CNT_W-1:0]        step;
  logic [CNT_W-1:0]        max_iter;

  logic signed [PW-1:0]    mul_xx;
  logic signed [PW-1:0]    mul_yy;
  logic signed [PW-1:0]    mul_xy;
  logic signed [PW-1:0]    sh_xx;
  logic signed [PW-1:0]    sh_yy;
  logic signed [PW-1:0]    sh_xy;
  logic signed [ZW-1:0]    cx_ext;
  logic signed [ZW-1:0]    cy_ext;
  logic signed [ZW-1:0]    zx_next;
  logic signed [ZW-1:0]    zy_next;
  logic [PW-1:0]           mag_sq;

  assign mul_xx = zx * zx;
  assign mul_yy = zy * zy;
  assign mul_xy = zx * zy;

  // arithmetic shift of an exact product is the floor
  assign sh_xx = p_xx >>> FRAC_BITS;
  assign sh_yy = p_yy >>> FRAC_BITS;
  assign sh_xy = p_xy >>> (FRAC_BITS - 1);

  assign cx_ext = {{(ZW-IN_W){c_re[IN_W-1]}}, c_re};
  assign cy_ext = {{(ZW-IN_W){c_im[IN_W-1]}}, c_im};

  assign zx_next = sh_xx[ZW-1:0] - sh_yy[ZW-1:0] + cx_ext;
  assign zy_next = sh_xy[ZW-1:0] + cy_ext;

  // squares are non-negative and each at most 2^(PW-2)
  assign mag_sq = $unsigned(p_xx) + $unsigned(p_yy);

  assign stat.escape   = mag_sq > ESC_LIM;
  assign stat.at_limit = step == max_iter;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter <= MAX_ITER_RST;
    end else if (cfg_wr_en) begin
      max_iter <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_re <= c_real;
      c_im <= c_imag;
      zx   <= '0;
      zy   <= '0;
      step <= '0;
    end else if (cmd.adv) begin
      zx   <= zx_next;
      zy   <= zy_next;
      step <= step + CNT_W'(1);
    end
    if (cmd.mul) begin
      p_xx <= mul_xx;
      p_yy <= mul_yy;
      p_xy <= mul_xy;
    end
    if (cmd.res_wr) begin
      // the products belong to z after step number (step - 1)
      iteration_count <= cmd.res_esc ? step - CNT_W'(1) : '0;
      escaped         <= cmd.res_esc;
    end
  end

endmodule

// ===== rtl/mbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbe_ctrl
// sequencer for one point at a time: load, multiply, test/update, and the
// valid flag of the result register
// ----------------------------------------------------------------------------
module mbe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                res_valid,
  input  logic                res_ready,
  input  mbe_pkg::mbe_stat_t  stat,
  output mbe_pkg::mbe_cmd_t   cmd
);
  import mbe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   res_valid_next;
  logic   slot_free;
  logic   finish;

  assign slot_free = !res_valid || res_ready;
  assign finish    = stat.escape || stat.at_limit;
  assign in_ready  = state == S_IDLE;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.res_esc = stat.escape;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        if (finish) begin
          // hold here until the result register can take the item
          if (slot_free) begin
            cmd.res_wr = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.adv    = 1'b1;
          state_next = S_MUL;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    res_valid_next = res_valid;
    if (cmd.res_wr) begin
      res_valid_next = 1'b1;
    end else if (res_ready) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

// ===== rtl/mbe_chk.sv =====
// ----------------------------------------------------------------------------
// mbe_chk
// port-level checks for the escape-time core, bound to the top level
// ----------------------------------------------------------------------------
module mbe_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        pt_valid,
  input logic                        pt_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [mbe_pkg::CNT_W-1:0]   res_count,
  input logic                        res_escaped
);
  import mbe_pkg::*;

  // a stalled result keeps its item
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_count) && $stable(res_escaped))
    else $error("result changed while stalled");

  // one point in flight: ready drops right after an accept
  a_one_point: assert property (@(posedge clk) disable iff (rst)
    pt_valid && pt_ready |=> !pt_ready)
    else $error("second point taken while iterating");

  // a point that stayed inside reports count zero
  a_inside_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_escaped |-> res_count == '0)
    else $error("non-zero count without escape");

  // reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind mandelbrot_escape_time_core mbe_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .pt_valid    (point.valid),
  .pt_ready    (point.ready),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_count   (result.iteration_count),
  .res_escaped (result.escaped)
);

// ===== dv/tb_mandelbrot_escape_time_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time_core
// self-checking bench for the escape-time core: points go in over the point
// channel, each accepted point is run through an exact fixed-point orbit
// model and the expected count/flag is queued, results are compared in order
// the run steps through several iteration limits (0, 1, 1023 among them) and
// idle/stall mixes on both channels
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time_core;
  import mbe_pkg::*;

  localparam int FRAC_BITS = 28;
  localparam int ONE       = 1 << FRAC_BITS;  // 1.0 in Q3.28
  localparam int IN_MAX    = (1 << (IN_W - 1)) - 1;
  localparam int IN_MIN    = -(1 << (IN_W - 1));
  localparam int NUM_DIR   = 22;

  // |z|^2 > 4 threshold, scaled by 2^(2F) since the squares are not renormalized
  localparam logic signed [127:0] ESC_BOUND = 128'sd4 <<< (2 * FRAC_BITS);

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             escaped;
  } escape_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: orbit model plus in-order queue of expected results
  // --------------------------------------------------------------------------
  class escape_scoreboard;
    logic [CNT_W-1:0] limit = MAX_ITER_RST;
    escape_result_t   expected_q[$];
    int unsigned      mismatches = 0;

    function void set_limit(logic [CNT_W-1:0] v);
      limit = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // z <- z*z + c from z = 0, exact products, floor on the rescale
    function escape_result_t run_orbit(logic signed [IN_W-1:0] cr, logic signed [IN_W-1:0] ci);
      logic signed [127:0] cx, cy, zx, zy, nx, ny;
      escape_result_t res;
      cx  = 128'(cr);
      cy  = 128'(ci);
      zx  = '0;
      zy  = '0;
      res = '0;
      for (int unsigned step = 0; step < limit; step++) begin
        nx = ((zx * zx) >>> FRAC_BITS) - ((zy * zy) >>> FRAC_BITS) + cx;
        ny = ((zx * zy) >>> (FRAC_BITS - 1)) + cy;
        zx = nx;
        zy = ny;
        if (zx * zx + zy * zy > ESC_BOUND) begin
          res.count   = CNT_W'(step);
          res.escaped = 1'b1;
          return res;
        end
      end
      return res;
    endfunction

    function void note_point(logic signed [IN_W-1:0] cr, logic signed [IN_W-1:0] ci);
      expected_q.push_back(run_orbit(cr, ci));
    endfunction

    function void check_result(logic [CNT_W-1:0] count, logic escaped);
      escape_result_t want;
      if (expected_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with nothing expected: count=%0d escaped=%0b",
                   $time, count, escaped);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (count !== want.count || escaped !== want.escaped) begin
        if (mismatches < 10)
          $display("%0t: result mismatch: expected count=%0d escaped=%0b, got count=%0d escaped=%0b",
                   $time, want.count, want.escaped, count, escaped);
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels, dut
  // --------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;

  mbe_point_if  point_ch ();
  mbe_result_if result_ch ();

  mandelbrot_escape_time_core #(
    .FRAC_BITS (FRAC_BITS)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .point       (point_ch),
    .result      (result_ch)
  );

  always #4 clk = ~clk;

  escape_scoreboard sb;

  // percentages of cycles the sender holds back / the receiver stalls
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  // directed points
  int dir_re [NUM_DIR];
  int dir_im [NUM_DIR];

  // receiver: ready changes only on the falling edge
  always @(negedge clk) begin
    result_ch.ready = ($urandom_range(1, 100) > stall_pct);
  end

  // result monitor, sampled on the rising edge
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_result(result_ch.iteration_count, result_ch.escaped);
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // one point; random idle cycles ahead of it, then hold until accepted
  task automatic send_point(input logic signed [IN_W-1:0] cr, input logic signed [IN_W-1:0] ci);
    @(negedge clk);
    while ($urandom_range(1, 100) <= idle_pct) begin
      point_ch.valid = 1'b0;
      @(negedge clk);
    end
    point_ch.valid  = 1'b1;
    point_ch.c_real = cr;
    point_ch.c_imag = ci;
    do @(posedge clk); while (!point_ch.ready);
    sb.note_point(cr, ci);
  endtask

  // every result has a point, so an empty queue means the core is idle
  task automatic drain_results();
    @(negedge clk);
    point_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    sb.set_limit(v);
  endtask

  // random point: mostly near the set boundary where orbits run long,
  // some from the main box and the +-2 square, some over the full field range
  task automatic pick_point(output logic signed [IN_W-1:0] cr,
                            output logic signed [IN_W-1:0] ci);
    int unsigned sel;
    int          span_re;
    int          span_im;
    int          base_re;
    int          base_im;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      cr = IN_W'($urandom);
      ci = IN_W'($urandom);
    end else if (sel <= 2) begin
      cr = IN_W'(int'($urandom_range(0, 2 * 536870912)) - 536870912);
      ci = IN_W'(int'($urandom_range(0, 2 * 536870912)) - 536870912);
    end else if (sel <= 4) begin
      // real -2.0 .. 0.5, imag -1.25 .. 1.25
      cr = IN_W'(int'($urandom_range(0, 671088640)) - 536870912);
      ci = IN_W'(int'($urandom_range(0, 671088640)) - 335544320);
    end else begin
      case ($urandom_range(0, 6))
        0: begin base_re =  67108864;  base_im = 0;         end  // cusp at 0.25
        1: begin base_re = -201326592; base_im = 0;         end  // neck at -0.75
        2: begin base_re = -335544320; base_im = 0;         end  // period-2 bulb edge
        3: begin base_re = -26843546;  base_im = 174483046; end  // upper bulb region
        4: begin base_re = -469762048; base_im = 0;         end  // period-3 window
        5: begin base_re =  80530637;  base_im = 134217728; end  // outer filaments
        default: begin base_re = -536870912; base_im = 0;   end  // tip at -2
      endcase
      // perturbation scale spread over many octaves gives a wide spread of counts
      span_re = 1 << $urandom_range(4, 22);
      span_im = 1 << $urandom_range(4, 22);
      cr = IN_W'(base_re + int'($urandom_range(0, 2 * span_re)) - span_re);
      ci = IN_W'(base_im + int'($urandom_range(0, 2 * span_im)) - span_im);
    end
  endtask

  // new limit once the core is idle, then a block of random points
  task automatic run_phase(input logic [CNT_W-1:0] lim, input int n,
                           input int unsigned ipct, input int unsigned spct);
    logic signed [IN_W-1:0] cr;
    logic signed [IN_W-1:0] ci;
    drain_results();
    write_limit(lim);
    idle_pct  = ipct;
    stall_pct = spct;
    for (int k = 0; k < n; k++) begin
      pick_point(cr, ci);
      send_point(cr, ci);
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new;
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    point_ch.valid  = 1'b0;
    point_ch.c_real = '0;
    point_ch.c_imag = '0;
    result_ch.ready = 1'b0;

    // directed set, run at the reset limit of 550:
    // origin, tips at +-2 on both axes, field extremes in all four corners,
    // periodic orbits at i and -1, the cusp just inside and just outside,
    // slow escape near the neck, lsb-sized points, a point just off -2
    dir_re = '{0, -2 * ONE, 2 * ONE, 0, 0,
               IN_MAX, IN_MIN, IN_MAX, IN_MIN,
               0, -ONE, ONE / 4, ONE / 4 + 1, ONE / 4 + ONE / 1024,
               -3 * ONE / 4, ONE, -2 * ONE, 1, -1,
               ONE / 2, -469762048, ONE / 4 + 4096};
    dir_im = '{0, 0, 0, 2 * ONE, -2 * ONE,
               IN_MAX, IN_MIN, IN_MIN, IN_MAX,
               ONE, 0, 0, 0, 0,
               ONE / 256, ONE, 1, -1, -1,
               -ONE / 2, 0, 0};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset value of the limit is checked before any write
    for (int k = 0; k < NUM_DIR; k++)
      send_point(IN_W'(dir_re[k]), IN_W'(dir_im[k]));

    // limit, points, sender idle %, receiver stall %
    run_phase(10'd1023,  30, 33, 33);  // longest orbits, both sides gappy
    run_phase(10'd0,     40, 72,  0);  // no step tried at all
    run_phase(10'd1,     60,  0, 72);  // single step, results pile up
    run_phase(10'd64,   200,  0,  0);  // back to back
    run_phase(10'd200,  160, 72,  0);
    run_phase(CNT_W'($urandom_range(2, 400)), 80, 0, 72);
    run_phase(10'd12,    80, 33, 33);

    drain_results();
    // room for a stray extra result from a worst-case orbit
    repeat (2 * 1023 + 8) @(posedge clk);

    if (sb.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
